// File: rtl/assert_macros.svh
// Assertion helpers for the RTL, included by pbm_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define PBM_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define PBM_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");
`else
`define PBM_ASSERT(lbl, clk, rstn, prop)
`define PBM_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// File: rtl/pbm_pkg.sv
package pbm_pkg;

	localparam int PIXEL_W = 32;
	localparam int COLOR_W = 15;
	localparam int INDEX_W = 8;
	localparam int STATUS_W = 3;
	localparam int USED_W = 9;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	typedef enum logic [0:0] {
		KIND_ADD = 1'b0,
		KIND_MAP = 1'b1
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_FOUND       = 3'd0,
		STAT_ADDED       = 3'd1,
		STAT_TRANSPARENT = 3'd2,
		STAT_NOT_FOUND   = 3'd3,
		STAT_FULL        = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	// classified transaction handed from front to back
	typedef struct packed {
		logic               transp;
		kind_t              kind;
		logic [COLOR_W-1:0] color;
	} op_t;

endpackage

// File: rtl/pbm_front.sv
module pbm_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   kind,
	input  logic [pbm_pkg::PIXEL_W-1:0] pixel,
	output logic                   q_valid,
	output pbm_pkg::op_t           q_entry,
	input  logic                   q_pop
);
	import pbm_pkg::*;

	op_t        buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	op_t        op_in;

	// RGB555 as r<<10 | g<<5 | b, top five bits of each channel
	always_comb begin
		op_in.transp = (pixel[31:24] != ALPHA_OPAQUE);
		op_in.kind   = kind_t'(kind);
		op_in.color  = {pixel[23:19], pixel[15:11], pixel[7:3]};
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_entry  = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

// File: rtl/pbm_back.sv
`include "assert_macros.svh"

module pbm_back #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  pbm_pkg::op_t                q_entry,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [pbm_pkg::INDEX_W-1:0]  index,
	output logic [pbm_pkg::STATUS_W-1:0] status,
	output logic [pbm_pkg::USED_W-1:0]   used_entries
);
	import pbm_pkg::*;

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	logic [COLOR_W-1:0] mem [TABLE_ENTRIES];

	state_t             state_q, state_d;
	op_t                op_q;
	logic [CW-1:0]      count_q;
	logic [IW-1:0]      rd_idx_q;
	logic               rd_vld_s1;
	logic [IW-1:0]      idx_s1;
	logic [COLOR_W-1:0] rd_data_s1;
	logic               hit_q;
	logic [IW-1:0]      hit_idx_q;

	logic               out_valid_q;
	logic [INDEX_W-1:0] index_q;
	status_t            status_q;
	logic [USED_W-1:0]  used_q;

	logic               start;
	logic               match;
	logic               last;
	logic               finish;
	logic               issue;
	logic               ld_out;
	logic               wr_en;
	logic [IW-1:0]      res_idx;
	status_t            res_status;
	logic [CW-1:0]      count_nxt;

	assign match  = rd_vld_s1 && (rd_data_s1 == op_q.color);
	assign last   = rd_vld_s1 && (CW'(idx_s1) == count_q - CW'(1));
	assign finish = match || last;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					if (q_entry.transp || count_q == CW'(1)) begin
						state_d = S_DONE;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (finish) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and result decision
	always_comb begin
		start      = 1'b0;
		issue      = 1'b0;
		ld_out     = 1'b0;
		wr_en      = 1'b0;
		res_idx    = '0;
		res_status = STAT_NOT_FOUND;
		count_nxt  = count_q;
		unique case (state_q)
			S_IDLE: begin
				start = q_valid;
			end
			S_SCAN: begin
				issue = !finish && (CW'(rd_idx_q) < count_q);
			end
			S_DONE: begin
				ld_out = !out_valid_q || !out_stall;
			end
			default: begin
			end
		endcase

		if (op_q.transp) begin
			res_status = STAT_TRANSPARENT;
		end else if (hit_q) begin
			res_idx    = hit_idx_q;
			res_status = STAT_FOUND;
		end else if (op_q.kind == KIND_ADD) begin
			if (count_q == CW'(TABLE_ENTRIES)) begin
				res_status = STAT_FULL;
			end else begin
				res_idx    = count_q[IW-1:0];
				res_status = STAT_ADDED;
				wr_en      = ld_out;
				count_nxt  = count_q + CW'(1);
			end
		end else if (op_q.color == '0 && count_q < CW'(TABLE_ENTRIES)) begin
			// unfilled entries are treated as holding zero
			res_idx    = count_q[IW-1:0];
			res_status = STAT_FOUND;
		end
	end

	assign q_pop = start;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[IW-1:0]] <= op_q.color;
		end
		rd_data_s1 <= mem[rd_idx_q];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q <= q_entry;
		end
		idx_s1 <= rd_idx_q;
		if (state_q == S_SCAN && finish) begin
			hit_idx_q <= idx_s1;
		end
		if (ld_out) begin
			index_q  <= INDEX_W'(res_idx);
			status_q <= res_status;
			used_q   <= USED_W'(count_nxt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= CW'(1);
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (start) begin
				rd_idx_q <= IW'(1);
				hit_q    <= 1'b0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + IW'(1);
			end
			if (state_q == S_SCAN && finish) begin
				hit_q <= match;
			end
			if (ld_out) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign index        = index_q;
	assign status       = status_q;
	assign used_entries = used_q;

	`PBM_ASSERT(a_count_range, clk, arst_n, (count_q != '0) && (count_q <= CW'(TABLE_ENTRIES)))
	`PBM_ASSERT(a_read_in_filled, clk, arst_n, rd_vld_s1 |-> (idx_s1 != '0) && (CW'(idx_s1) < count_q))
	`PBM_ASSERT(a_count_on_add, clk, arst_n, (ld_out && res_status == STAT_ADDED) |=> count_q == $past(count_q) + CW'(1))
	`PBM_ASSERT(a_count_hold, clk, arst_n, !(ld_out && res_status == STAT_ADDED) |=> count_q == $past(count_q))
	`PBM_ASSERT_NEVER(a_write_outside_done, clk, arst_n, wr_en && state_q != S_DONE)

endmodule

// File: rtl/palette_build_and_map.sv
// Flow: a transparent pixel or an empty table goes straight to the result; otherwise
//   the scan reads one palette entry per cycle until a match or the last filled entry.
// The scan runs over the single palette memory read port, and a new transaction is
//   taken only once the previous result has been loaded; a two-entry queue decouples input.
// Reset: entry count returns to 1, queue and output empty; palette memory is not
//   cleared, only filled entries are ever read.
module palette_build_and_map #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         kind,
	input  logic [pbm_pkg::PIXEL_W-1:0]  pixel,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [pbm_pkg::INDEX_W-1:0]  index,
	output logic [pbm_pkg::STATUS_W-1:0] status,
	output logic [pbm_pkg::USED_W-1:0]   used_entries
);
	import pbm_pkg::*;

	logic q_valid;
	op_t  q_entry;
	logic q_pop;

	pbm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.pixel    (pixel),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.q_pop    (q_pop)
	);

	pbm_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_entry      (q_entry),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.index        (index),
		.status       (status),
		.used_entries (used_entries)
	);

endmodule

// File: tb/sv/tb_palette_build_and_map.sv
module tb_palette_build_and_map;
	timeunit 1ns;
	timeprecision 1ps;

	import pbm_pkg::*;

	localparam int PAL_DEPTH    = 256;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 300;

	typedef struct {
		logic [INDEX_W-1:0] slot;
		status_t            status;
		logic [USED_W-1:0]  used;
	} map_result_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic                px_kind   = 1'b0;
	logic [PIXEL_W-1:0]  pixel     = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [INDEX_W-1:0]  res_index;
	logic [STATUS_W-1:0] res_status;
	logic [USED_W-1:0]   res_used;

	logic [COLOR_W-1:0] pal_colors [PAL_DEPTH];
	int unsigned        pal_count;
	map_result_t        expected_results [$];
	int                 mismatches   = 0;
	int                 quiet_cycles = 0;
	int                 burst_left   = 0;
	int                 stall_mode   = 0;
	int                 stall_left   = 0;

	palette_build_and_map #(
		.TABLE_ENTRIES(PAL_DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (px_kind),
		.pixel        (pixel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.index        (res_index),
		.status       (res_status),
		.used_entries (res_used)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [COLOR_W-1:0] to_rgb555(logic [PIXEL_W-1:0] px);
		return {px[23:19], px[15:11], px[7:3]};
	endfunction

	// lowest entry in 1..limit-1 holding c, 0 if none
	function automatic int find_color(logic [COLOR_W-1:0] c, int unsigned limit);
		for (int i = 1; i < limit; i++) begin
			if (pal_colors[i] == c)
				return i;
		end
		return 0;
	endfunction

	function automatic map_result_t predict_result(kind_t k, logic [PIXEL_W-1:0] px);
		map_result_t        r;
		int                 hit;
		logic [COLOR_W-1:0] c;
		r.slot = '0;
		c = to_rgb555(px);
		if (px[31:24] != ALPHA_OPAQUE) begin
			r.status = STAT_TRANSPARENT;
		end else if (k == KIND_ADD) begin
			hit = find_color(c, pal_count);
			if (hit != 0) begin
				r.slot = INDEX_W'(hit);
				r.status = STAT_FOUND;
			end else if (pal_count >= PAL_DEPTH) begin
				r.status = STAT_FULL;
			end else begin
				pal_colors[pal_count] = c;
				r.slot = INDEX_W'(pal_count);
				pal_count++;
				r.status = STAT_ADDED;
			end
		end else begin
			// map searches the whole table, unfilled entries included
			hit = find_color(c, PAL_DEPTH);
			if (hit != 0) begin
				r.slot = INDEX_W'(hit);
				r.status = STAT_FOUND;
			end else begin
				r.status = STAT_NOT_FOUND;
			end
		end
		r.used = USED_W'(pal_count);
		return r;
	endfunction

	function automatic logic [PIXEL_W-1:0] random_pixel();
		int                 sel;
		logic [COLOR_W-1:0] c;
		logic [PIXEL_W-1:0] px;
		sel = $urandom_range(0, 99);
		px = {ALPHA_OPAQUE, 24'($urandom)};
		if (sel < 12) begin
			px[31:24] = 8'($urandom_range(0, 254));
		end else if (sel < 20) begin
			px[23:0] = {5'd0, 3'($urandom), 5'd0, 3'($urandom), 5'd0, 3'($urandom)};
		end else if (sel < 60 && pal_count > 1) begin
			// known color, low bits scrambled
			c = pal_colors[$urandom_range(1, pal_count - 1)];
			px[23:0] = {c[14:10], 3'($urandom), c[9:5], 3'($urandom),
				c[4:0], 3'($urandom)};
		end
		return px;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s got %0d expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
				: $urandom_range(0, 16);
		end
	endtask

	// called just after a rising edge; returns just after the accepting edge or the pause that follows it
	task automatic send_pixel(kind_t k, logic [PIXEL_W-1:0] px);
		logic stalled;
		px_kind <= k;
		pixel <= px;
		in_valid <= 1'b1;
		stalled = 1'b1;
		while (stalled) begin
			@(negedge clk);
			stalled = (in_stall !== 1'b0);
			if (!stalled)
				expected_results.push_back(predict_result(k, px));
			@(posedge clk);
		end
		pace_sender();
	endtask

	task automatic test_transparent();
		send_pixel(KIND_MAP, 32'h0000_0000);
		send_pixel(KIND_ADD, 32'hFEFF_FFFF);
		send_pixel(KIND_ADD, 32'h7F12_3456);
		send_pixel(KIND_MAP, 32'h80FF_FFFF);
		send_pixel(KIND_ADD, 32'h0000_0000);
	endtask

	task automatic test_empty_table_map();
		send_pixel(KIND_MAP, 32'hFF00_0000);
		send_pixel(KIND_MAP, 32'hFF07_0707);
		send_pixel(KIND_MAP, 32'hFFFF_FFFF);
	endtask

	task automatic test_add_and_lookup();
		send_pixel(KIND_ADD, 32'hFFFF_FFFF);
		send_pixel(KIND_ADD, 32'hFFF8_F8F8);
		send_pixel(KIND_ADD, 32'hFF00_0000);
		send_pixel(KIND_MAP, 32'hFF00_0000);
		send_pixel(KIND_MAP, 32'hFF05_0301);
		send_pixel(KIND_ADD, 32'hFF00_00FF);
		send_pixel(KIND_ADD, 32'hFF00_FF00);
		send_pixel(KIND_ADD, 32'hFFFF_0000);
		send_pixel(KIND_MAP, 32'hFF00_00F8);
		send_pixel(KIND_MAP, 32'hFF00_FF00);
		send_pixel(KIND_MAP, 32'hFF12_3456);
		send_pixel(KIND_ADD, 32'hFF00_FF07);
		send_pixel(KIND_MAP, 32'hFFFF_FFFF);
	endtask

	task automatic test_random_mix(int count);
		for (int n = 0; n < count; n++)
			send_pixel(kind_t'($urandom_range(0, 1)), random_pixel());
	endtask

	task automatic test_fill_table();
		while (pal_count < PAL_DEPTH)
			send_pixel(KIND_ADD, {ALPHA_OPAQUE, 24'($urandom)});
	endtask

	task automatic test_full_table();
		logic [PIXEL_W-1:0] px;
		do
			px = {ALPHA_OPAQUE, 24'($urandom)};
		while (find_color(to_rgb555(px), PAL_DEPTH) != 0);
		send_pixel(KIND_ADD, px);
		send_pixel(KIND_MAP, px);
		send_pixel(KIND_ADD, 32'hFF00_0000);
		send_pixel(KIND_ADD, 32'hFFFF_FFFF);
		send_pixel(KIND_ADD, {8'h00, px[23:0]});
		test_random_mix(550);
	endtask

	// result receiver stall pattern
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(50, 400);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 99) < 40);
			default: out_stall <= ($urandom_range(0, 99) < 85);
		endcase
	end

	// values are stable at the falling edge and hold through the next rising edge
	always @(negedge clk) begin : check_results
		map_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected transaction, index", 32'(res_index), 0);
			end else begin
				want = expected_results.pop_front();
				if (res_index !== want.slot)
					report_mismatch("index", 32'(res_index), 32'(want.slot));
				if (res_status !== want.status)
					report_mismatch("status", 32'(res_status), 32'(want.status));
				if (res_used !== want.used)
					report_mismatch("used_entries", 32'(res_used), 32'(want.used));
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < PAL_DEPTH; i++)
			pal_colors[i] = '0;
		pal_count = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_transparent();
		test_empty_table_map();
		test_add_and_lookup();
		test_random_mix(1100);
		test_fill_table();
		test_full_table();

		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
